[design/mips_subset_instruction_execute_assert.svh]
// Assertion macros shared by the execute block.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MIPS_EX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("execute block assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MIPS_EX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("execute block assertion failed");

`endif

[design/mips_ex_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mips_ex_pkg;

   // Data memory depth in words; a power of two so the word index wraps by masking.
   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam int NUM_REGS = 32;
   localparam int REG_AW   = $clog2(NUM_REGS);

   localparam logic [31:0] PC_RESET    = 32'h0040_0000;
   localparam logic [31:0] TARGET_MASK = 32'h03FF_FFFF;
   localparam logic [31:0] REGION_MASK = 32'hF000_0000;
   localparam logic [31:0] IMM_MASK    = 32'h0000_FFFF;

   // Primary opcodes.
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   // Function codes under the special opcode.
   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_NOR  = 6'd39;
   localparam logic [5:0] FN_SLT  = 6'd42;
   localparam logic [5:0] FN_SLTU = 6'd43;

   // Outcome of executing one instruction.
   typedef struct packed {
      logic [31:0]       next_pc;
      logic              wr;
      logic [REG_AW-1:0] dst;
      logic [31:0]       value;
      logic              load;
      logic              store;
      logic              illegal;
      logic [MEM_AW-1:0] mem_index;
   } exec_type;

   // One register file write, also used as a bypass source.
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [31:0]       data;
   } reg_write_type;

endpackage

`default_nettype wire

[design/mips_ex_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mips_ex_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/mips_ex_regfile.sv]
`timescale 1ns / 1ps
`default_nettype none

module mips_ex_regfile import mips_ex_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [REG_AW-1:0] rd_addr_a,
   input  wire logic [REG_AW-1:0] rd_addr_b,
   input  wire logic [REG_AW-1:0] src_a,
   input  wire logic [REG_AW-1:0] src_b,
   input  wire reg_write_type     fwd,
   input  wire reg_write_type     wr,
   output logic [31:0]            op_a,
   output logic [31:0]            op_b
);

   logic [NUM_REGS-1:0] valid_ff;
   reg_write_type       wb_ff;
   logic [31:0]         ram_a;
   logic [31:0]         ram_b;

   // Both copies take every write so each can serve one read address.
   mips_ex_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_a (
      .clock(clock), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
      .re(rd_en), .raddr(rd_addr_a), .rdata(ram_a)
   );

   mips_ex_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_b (
      .clock(clock), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
      .re(rd_en), .raddr(rd_addr_b), .rdata(ram_b)
   );

   // A register never written since reset reads as zero. The last write is
   // kept because it landed at or after the read and is missing from the RAM data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wb_ff    <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
         wb_ff             <= wr;
      end
   end

   function automatic logic [31:0] pick(input logic [REG_AW-1:0] idx,
                                        input logic [31:0] ram_data,
                                        input reg_write_type near,
                                        input reg_write_type last,
                                        input logic [NUM_REGS-1:0] valid);
      logic [31:0] result;
      if (near.en && near.addr == idx) begin
         result = near.data;
      end else if (last.en && last.addr == idx) begin
         result = last.data;
      end else if (valid[idx]) begin
         result = ram_data;
      end else begin
         result = '0;
      end
      return result;
   endfunction

   always_comb begin
      op_a = pick(src_a, ram_a, fwd, wb_ff, valid_ff);
      op_b = pick(src_b, ram_b, fwd, wb_ff, valid_ff);
   end

endmodule

`default_nettype wire

[design/mips_ex_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module mips_ex_alu import mips_ex_pkg::*; (
   input  wire logic [31:0] instruction,
   input  wire logic [31:0] pc,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output exec_type         ex
);

   logic [5:0]        op;
   logic [5:0]        fn;
   logic [REG_AW-1:0] rt;
   logic [REG_AW-1:0] rd;
   logic [4:0]        sh;
   logic [31:0]       imm;
   logic [31:0]       simm;
   logic [31:0]       seq;
   logic [31:0]       addr;
   exec_type          raw;

   always_comb begin
      op   = instruction[31:26];
      rt   = instruction[20:16];
      rd   = instruction[15:11];
      sh   = instruction[10:6];
      fn   = instruction[5:0];
      imm  = instruction & IMM_MASK;
      simm = {{16{instruction[15]}}, instruction[15:0]};
      seq  = pc + 32'd4;
      addr = op_a + simm;

      raw           = '0;
      raw.next_pc   = seq;
      raw.mem_index = addr[MEM_AW+1:2];

      case (op)
         OP_SPECIAL: begin
            raw.wr  = 1'b1;
            raw.dst = rd;
            case (fn)
               FN_ADD, FN_ADDU: raw.value = op_a + op_b;
               FN_SUB, FN_SUBU: raw.value = op_a - op_b;
               FN_AND:          raw.value = op_a & op_b;
               FN_OR:           raw.value = op_a | op_b;
               FN_NOR:          raw.value = ~(op_a | op_b);
               FN_SLT:          raw.value = {31'd0, $signed(op_a) < $signed(op_b)};
               FN_SLTU:         raw.value = {31'd0, op_a < op_b};
               FN_SLL:          raw.value = op_b << sh;
               FN_SRL:          raw.value = op_b >> sh;
               FN_JR: begin
                  raw.wr      = 1'b0;
                  raw.next_pc = op_a;
               end
               default:         raw.illegal = 1'b1;
            endcase
         end
         OP_ADDI, OP_ADDIU: begin
            raw.wr    = 1'b1;
            raw.dst   = rt;
            raw.value = addr;
         end
         OP_SLTI: begin
            raw.wr    = 1'b1;
            raw.dst   = rt;
            raw.value = {31'd0, $signed(op_a) < $signed(simm)};
         end
         OP_SLTIU: begin
            raw.wr    = 1'b1;
            raw.dst   = rt;
            raw.value = {31'd0, op_a < simm};
         end
         OP_ANDI: begin
            raw.wr    = 1'b1;
            raw.dst   = rt;
            raw.value = op_a & imm;
         end
         OP_ORI: begin
            raw.wr    = 1'b1;
            raw.dst   = rt;
            raw.value = op_a | imm;
         end
         OP_LW: begin
            raw.wr   = 1'b1;
            raw.dst  = rt;
            raw.load = 1'b1;
         end
         OP_SW:   raw.store = 1'b1;
         OP_J:    raw.next_pc = (seq & REGION_MASK) | ((instruction & TARGET_MASK) << 2);
         default: raw.illegal = 1'b1;
      endcase

      ex = raw;
      if (raw.illegal) begin
         // Nothing changes: the PC stays, the illegal flag is set and every other field reads zero.
         ex         = '0;
         ex.illegal = 1'b1;
         ex.next_pc = pc;
      end else if (!raw.wr || raw.dst == '0) begin
         // A write to register zero is dropped and reported as no write.
         ex.wr    = 1'b0;
         ex.dst   = '0;
         ex.value = '0;
         ex.load  = 1'b0;
      end
   end

endmodule

`default_nettype wire

[design/mips_subset_instruction_execute.sv]
// A request accepted into the execute stage register has its result registered in
// the output register; a result left waiting there stalls the execute stage.
// Throughput: one request per cycle while results are taken, sustained through load-use
// and write-read chains; the register read, execute and write-back loop is closed by
// bypassing. Reset: synchronous; the PC returns to 0x00400000, registers read as zero,
// and the data memory is swept to zero, one word at a time, while no request is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "mips_subset_instruction_execute_assert.svh"

module mips_subset_instruction_execute import mips_ex_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_instruction,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_stored,
   output logic             rsp_status
);

   // Pipeline:
   //   accept  - rs and rt are presented to the register file RAMs.
   //   execute - operands arrive (with bypass), the ALU works, the PC advances,
   //             stores write the data memory and loads issue their read.
   //   result  - the output register; load data comes straight from the data
   //             memory read register, and register write-back happens when the
   //             result request is taken.

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [31:0]       s1_instr_ff;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   exec_type          s2_ff;
   logic [31:0]       pc_ff;
   logic              clearing_ff;
   logic [MEM_AW-1:0] clear_addr_ff;

   logic              accept;
   logic              s1_adv;
   logic              retire;
   exec_type          ex;
   logic [31:0]       op_a;
   logic [31:0]       op_b;
   logic [31:0]       dmem_rdata;
   logic [31:0]       s2_value;
   reg_write_type     rf_fwd;
   reg_write_type     rf_wr;
   logic              dmem_we;
   logic [MEM_AW-1:0] dmem_waddr;
   logic [31:0]       dmem_wdata;
   logic              dmem_re;

   // Handshake. The execute stage moves on whenever the output register is
   // empty or being emptied. A result left waiting holds the execute stage,
   // and once that stage is occupied the request port is held as well.
   always_comb begin
      s1_adv    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
      retire    = s2_valid_ff && rsp_ready;
      req_ready = !clearing_ff && (!s1_valid_ff || s1_adv);
      accept    = req_valid && req_ready;

      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      s2_valid_in = s1_adv || (s2_valid_ff && !retire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instruction;
      end
      if (s1_adv) begin
         s2_ff <= ex;
      end
   end

   // The PC is the only state an instruction changes in the execute stage
   // besides a store; an illegal instruction carries the unchanged PC.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
      end else if (s1_adv) begin
         pc_ff <= ex.next_pc;
      end
   end

   // After reset the whole data memory is written with zero, one word a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == MEM_AW'(MEM_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // The result register's value, with load data taken from the memory read port.
   assign s2_value = s2_ff.load ? dmem_rdata : s2_ff.value;

   always_comb begin
      rf_fwd.en   = s2_valid_ff && s2_ff.wr;
      rf_fwd.addr = s2_ff.dst;
      rf_fwd.data = s2_value;

      rf_wr.en    = retire && s2_ff.wr;
      rf_wr.addr  = s2_ff.dst;
      rf_wr.data  = s2_value;
   end

   mips_ex_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr_a(req_instruction[25:21]),
      .rd_addr_b(req_instruction[20:16]),
      .src_a    (s1_instr_ff[25:21]),
      .src_b    (s1_instr_ff[20:16]),
      .fwd      (rf_fwd),
      .wr       (rf_wr),
      .op_a     (op_a),
      .op_b     (op_b)
   );

   mips_ex_alu u_alu (
      .instruction(s1_instr_ff),
      .pc         (pc_ff),
      .op_a       (op_a),
      .op_b       (op_b),
      .ex         (ex)
   );

   // Stores write and loads read the data memory in the same stage, so a load
   // always sees every earlier store without any bypass.
   always_comb begin
      dmem_we    = clearing_ff || (s1_adv && ex.store);
      dmem_waddr = clearing_ff ? clear_addr_ff : ex.mem_index;
      dmem_wdata = clearing_ff ? 32'd0 : op_b;
      dmem_re    = s1_adv && ex.load;
   end

   mips_ex_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
      .clock(clock),
      .we   (dmem_we),
      .waddr(dmem_waddr),
      .wdata(dmem_wdata),
      .re   (dmem_re),
      .raddr(ex.mem_index),
      .rdata(dmem_rdata)
   );

   always_comb begin
      rsp_valid       = s2_valid_ff;
      rsp_next_pc     = s2_ff.next_pc;
      rsp_reg_written = s2_ff.wr;
      rsp_dest_index  = s2_ff.dst;
      rsp_dest_value  = s2_value;
      rsp_stored      = s2_ff.store;
      rsp_status      = s2_ff.illegal;
   end

   // No request is taken while the data memory is being cleared.
   `MIPS_EX_ASSERT_NOW(a_no_accept_clearing, clock, reset, clearing_ff, !req_ready)
   // An illegal instruction reports no register write and no store.
   `MIPS_EX_ASSERT_NOW(a_illegal_quiet, clock, reset, rsp_valid && rsp_status,
                       !rsp_reg_written && !rsp_stored && rsp_dest_index == '0)
   // Register zero is never the target of a write-back.
   `MIPS_EX_ASSERT_NOW(a_no_zero_write, clock, reset, rf_wr.en, rf_wr.addr != '0)
   // The PC moves only when an instruction leaves the execute stage.
   `MIPS_EX_ASSERT_NEXT(a_pc_holds, clock, reset, !s1_adv, $stable(pc_ff))

endmodule

`default_nettype wire
